### rtl/core/marker_length_frame_receiver_assert.svh
`ifndef MARKER_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define MARKER_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// concurrent checks, compiled out for synthesis
`ifndef SYNTHESIS
`define MLFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mlfr assertion failed");
`define MLFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mlfr forbidden condition seen");
`else
`define MLFR_ASSERT(lbl, clk, rst_n, prop)
`define MLFR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/core/mlfr_pkg.sv
package mlfr_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_FIRST_MARKER  = 2'd0;
  localparam logic [1:0] REG_SECOND_MARKER = 2'd1;
  localparam logic [1:0] REG_END_MARKER    = 2'd2;

  typedef struct packed {
    logic [7:0] first_marker;
    logic [7:0] second_marker;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic clr_idx;
    logic rd_en;
    logic load_out;
    logic inc_idx;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic out_free;
    logic idx_last;
  } status_t;

endpackage

### rtl/core/mlfr_ram.sv
module mlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mlfr_regs.sv
module mlfr_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mlfr_pkg::ADDR_W-1:0] paddr,
  input  logic [mlfr_pkg::DATA_W-1:0] pwdata,
  output logic [mlfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mlfr_pkg::cfg_t             cfg_o
);
  import mlfr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_FIRST_MARKER:  cfg_d.first_marker  = pwdata[7:0];
        REG_SECOND_MARKER: cfg_d.second_marker = pwdata[7:0];
        REG_END_MARKER:    cfg_d.end_marker    = pwdata[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST_MARKER:  prdata = {24'b0, cfg_q.first_marker};
      REG_SECOND_MARKER: prdata = {24'b0, cfg_q.second_marker};
      REG_END_MARKER:    prdata = {24'b0, cfg_q.end_marker};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/mlfr_dpath.sv
`include "marker_length_frame_receiver_assert.svh"

module mlfr_dpath #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlfr_pkg::cfg_t      cfg_i,
  input  mlfr_pkg::cmd_t      cmd_i,
  output mlfr_pkg::status_t   status_o,
  input  logic [7:0]          rx_byte_i,
  output logic                frame_valid_o,
  input  logic                frame_stall_i,
  output logic [7:0]          frame_byte_o,
  output logic [3:0]          byte_position_o,
  output logic                last_of_frame_o
);
  import mlfr_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int PW = (CW < 4) ? CW : 4;

  typedef enum logic [1:0] {
    HUNT_NONE   = 2'd0,
    HUNT_FIRST  = 2'd1,
    HUNT_LENGTH = 2'd2
  } hunt_e;

  hunt_e         hunt_q, hunt_d;
  logic          recv_q, recv_d;
  logic          held_q, held_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] exp_q, exp_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_inc;
  logic          len_ok;
  logic          frame_end;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic [3:0]    out_pos_q;
  logic          out_last_q;
  logic [7:0]    rd_data;

  assign cnt_inc   = cnt_q + CW'(1);
  assign frame_end = recv_q && (cnt_inc >= exp_q);
  assign len_ok    = (rx_byte_i >= 8'd2) && (9'(rx_byte_i) <= 9'(FRAME_BYTES + 1));

  assign status_o.frame_ok = frame_end && (rx_byte_i == cfg_i.end_marker);
  assign status_o.out_free = !out_valid_q || !frame_stall_i;
  assign status_o.idx_last = ((idx_q + CW'(1)) == len_q);

  always_comb begin
    hunt_d = hunt_q;
    recv_d = recv_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    len_d  = len_q;
    if (cmd_i.accept) begin
      priority if (recv_q) begin
        cnt_d = cnt_inc;
        if (frame_end) begin
          recv_d = 1'b0;
          cnt_d  = '0;
          exp_d  = '0;
          hunt_d = HUNT_NONE;
          if (rx_byte_i == cfg_i.end_marker) begin
            held_d = 1'b1;
            len_d  = exp_q;
          end
        end
      end else if (held_q) begin
        held_d = 1'b0;
      end else if (rx_byte_i == cfg_i.first_marker) begin
        hunt_d = HUNT_FIRST;
      end else if (rx_byte_i == cfg_i.second_marker && hunt_q == HUNT_FIRST) begin
        hunt_d = HUNT_LENGTH;
      end else if (hunt_q == HUNT_LENGTH) begin
        hunt_d = HUNT_NONE;
        if (len_ok) begin
          recv_d = 1'b1;
          cnt_d  = '0;
          exp_d  = CW'(rx_byte_i - 8'd1);
        end
      end else begin
        hunt_d = HUNT_NONE;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!frame_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q      <= HUNT_NONE;
      recv_q      <= 1'b0;
      held_q      <= 1'b0;
      cnt_q       <= '0;
      exp_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hunt_q      <= hunt_d;
      recv_q      <= recv_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      exp_q       <= exp_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q <= rd_data;
      out_pos_q  <= 4'(idx_q[PW-1:0]);
      out_last_q <= status_o.idx_last;
    end
  end

  mlfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && recv_q),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign frame_valid_o   = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign last_of_frame_o = out_last_q;

  `MLFR_ASSERT(a_cnt_in_range, clk_i, rst_ni, recv_q |-> (cnt_q < exp_q))
  `MLFR_ASSERT(a_held_idle, clk_i, rst_ni, held_q |-> (!recv_q && hunt_q == HUNT_NONE))
  `MLFR_ASSERT_NEVER(a_load_over, clk_i, rst_ni, cmd_i.load_out && out_valid_q && frame_stall_i)

endmodule

### rtl/core/mlfr_ctrl.sv
`include "marker_length_frame_receiver_assert.svh"

module mlfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  mlfr_pkg::status_t status_i,
  output mlfr_pkg::cmd_t    cmd_o
);
  import mlfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_WAIT = 2'd2
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && rx_valid_i;
    cmd_o.clr_idx  = cmd_o.accept && status_i.frame_ok;
    cmd_o.rd_en    = (state_q == ST_READ);
    cmd_o.load_out = (state_q == ST_WAIT) && status_i.out_free;
    cmd_o.inc_idx  = cmd_o.load_out && !status_i.idx_last;
  end

  assign rx_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.clr_idx) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: begin
        if (status_i.out_free) begin
          state_d = status_i.idx_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MLFR_ASSERT(a_frame_starts_read, clk_i, rst_ni, cmd_o.clr_idx |=> cmd_o.rd_en)

endmodule

### rtl/core/marker_length_frame_receiver.sv
// Receives one serial byte per request and hunts for a first marker, a second marker and a
// length byte L (2..FRAME_BYTES+1); the following L-1 bytes go into an on-chip buffer, and
// when the last of them equals the end marker the whole buffer is sent out, one request per
// byte with its position and a last flag. Frames with a bad trailer or length are dropped
// silently, and the byte after a sent frame is discarded; the input stalls only while a frame
// drains, which starts after a good trailer. Each stored byte is read from the buffer and then
// loaded into the output register; that load waits while a held output byte is stalled. The
// input opens again as soon as the final byte sits in the output register.
// Marker registers at byte addresses 0, 4 and 8 reset to zero and keep only bits 7:0.
module marker_length_frame_receiver #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlfr_pkg::ADDR_W-1:0] paddr,
  input  logic [mlfr_pkg::DATA_W-1:0] pwdata,
  output logic [mlfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        rx_valid_i,
  output logic                        rx_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        frame_valid_o,
  input  logic                        frame_stall_i,
  output logic [7:0]                  frame_byte_o,
  output logic [3:0]                  byte_position_o,
  output logic                        last_of_frame_o
);
  import mlfr_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mlfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlfr_dpath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_o   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

### verif/marker_length_frame_receiver_checker.sv
module marker_length_frame_receiver_checker #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlfr_pkg::ADDR_W-1:0] paddr,
  input  logic [mlfr_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  input  logic                        rx_valid_i,
  input  logic                        rx_stall_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        frame_valid_o,
  input  logic                        frame_stall_i,
  input  logic [7:0]                  frame_byte_o,
  input  logic [3:0]                  byte_position_o,
  input  logic                        last_of_frame_o,
  output int                          mismatches_o,
  output int                          beats_pending_o,
  output int                          frames_passed_o,
  output int                          beats_compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HUNT_NONE, HUNT_FIRST, HUNT_LENGTH} hunt_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] position;
    logic       last;
  } frame_beat_t;

  mlfr_pkg::cfg_t markers;
  hunt_e          hunt;
  logic           receiving;
  logic           held;
  int             stored;
  int             wanted;
  logic [7:0]     payload_store [FRAME_BYTES];
  frame_beat_t    beats_due [$];
  int             mismatches = 0;
  int             frames_passed = 0;
  int             beats_compared = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b);
    frame_beat_t beat;
    if (receiving) begin
      if (stored < FRAME_BYTES) payload_store[stored] = b;
      stored++;
      if (stored >= wanted) begin
        if (b == markers.end_marker) begin
          held = 1'b1;
          frames_passed++;
          for (int k = 0; k < wanted && k < FRAME_BYTES; k++) begin
            beat.data     = payload_store[k];
            beat.position = k[3:0];
            beat.last     = (k + 1 == wanted);
            beats_due.push_back(beat);
          end
        end
        receiving = 1'b0;
        stored    = 0;
        wanted    = 0;
        hunt      = HUNT_NONE;
      end
    end else if (held) begin
      held = 1'b0;
    end else if (b == markers.first_marker) begin
      hunt = HUNT_FIRST;
    end else if (b == markers.second_marker && hunt == HUNT_FIRST) begin
      hunt = HUNT_LENGTH;
    end else if (hunt == HUNT_LENGTH) begin
      hunt = HUNT_NONE;
      if (b >= 2 && b <= FRAME_BYTES + 1) begin
        receiving = 1'b1;
        stored    = 0;
        wanted    = b - 1;
      end
    end else begin
      hunt = HUNT_NONE;
    end
  endtask

  task automatic compare_frame_beat();
    frame_beat_t want;
    if (beats_due.size() == 0) begin
      report_mismatch("frame byte with none outstanding", frame_byte_o, 0);
      return;
    end
    want = beats_due.pop_front();
    beats_compared++;
    if (frame_byte_o !== want.data) begin
      report_mismatch("frame_byte", frame_byte_o, want.data);
    end
    if (byte_position_o !== want.position) begin
      report_mismatch("byte_position", byte_position_o, want.position);
    end
    if (last_of_frame_o !== want.last) begin
      report_mismatch("last_of_frame", last_of_frame_o, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers   = '0;
      hunt      = HUNT_NONE;
      receiving = 1'b0;
      held      = 1'b0;
      stored    = 0;
      wanted    = 0;
      beats_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[mlfr_pkg::ADDR_W-1:2])
          mlfr_pkg::REG_FIRST_MARKER:  markers.first_marker  = pwdata[7:0];
          mlfr_pkg::REG_SECOND_MARKER: markers.second_marker = pwdata[7:0];
          mlfr_pkg::REG_END_MARKER:    markers.end_marker    = pwdata[7:0];
          default: ;
        endcase
      end
      if (frame_valid_o && !frame_stall_i) compare_frame_beat();
      if (rx_valid_i && !rx_stall_o) absorb_rx_byte(rx_byte_i);
    end
    mismatches_o     <= mismatches;
    beats_pending_o  <= beats_due.size();
    frames_passed_o  <= frames_passed;
    beats_compared_o <= beats_compared;
  end

endmodule

### verif/marker_length_frame_receiver_tb.sv
module marker_length_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = 16;
  localparam int PHASE_ITEMS = 75;
  localparam int STALL_LIMIT = 2000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [mlfr_pkg::ADDR_W-1:0] paddr = '0;
  logic [mlfr_pkg::DATA_W-1:0] pwdata = '0;
  logic [mlfr_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        rx_valid_i = 1'b0;
  logic                        rx_stall_o;
  logic [7:0]                  rx_byte_i = '0;
  logic                        frame_valid_o;
  logic                        frame_stall_i = 1'b0;
  logic [7:0]                  frame_byte_o;
  logic [3:0]                  byte_position_o;
  logic                        last_of_frame_o;

  int         mismatches;
  int         beats_pending;
  int         frames_passed;
  int         beats_compared;
  int         bytes_sent = 0;
  int         settings_used = 0;
  int         quiet_cycles = 0;
  logic       steady = 1'b0;
  logic [7:0] first_mk = '0;
  logic [7:0] second_mk = '0;
  logic [7:0] end_mk = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  marker_length_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (.*);

  marker_length_frame_receiver_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_checker (
    .mismatches_o    (mismatches),
    .beats_pending_o (beats_pending),
    .frames_passed_o (frames_passed),
    .beats_compared_o(beats_compared),
    .*
  );

  always @(negedge clk_i) begin
    frame_stall_i <= !steady && ($urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && !rx_stall_o) || (frame_valid_o && !frame_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    while (!steady && $urandom_range(99) < 17) begin
      @(negedge clk_i) rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (rx_stall_o);
    bytes_sent++;
  endtask

  task automatic apb_write(input logic [1:0] reg_sel, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {24'b0, value};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // enough neutral bytes to finish any frame in flight and leave the hunt idle
  task automatic set_markers(input logic [7:0] first_v, second_v, end_v);
    logic [7:0] filler;
    for (int i = 0; i <= FRAME_BYTES; i++) begin
      do filler = 8'($urandom);
      while (filler == first_mk || filler == second_mk || filler == end_mk);
      send_byte(filler);
    end
    @(negedge clk_i) rx_valid_i <= 1'b0;
    while (beats_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    apb_write(mlfr_pkg::REG_FIRST_MARKER, first_v);
    apb_write(mlfr_pkg::REG_SECOND_MARKER, second_v);
    apb_write(mlfr_pkg::REG_END_MARKER, end_v);
    first_mk  = first_v;
    second_mk = second_v;
    end_mk    = end_v;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_payload();
    if ($urandom_range(9) != 0) return 8'($urandom);
    case ($urandom_range(2))
      0:       return first_mk;
      1:       return second_mk;
      default: return end_mk;
    endcase
  endfunction

  task automatic send_random_chunk(inout int counted);
    int         pick;
    int         len;
    logic [7:0] tail;
    pick = $urandom_range(99);
    if (pick < 70) begin
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(2, 6);
      else if (pick < 93) len = $urandom_range(2, FRAME_BYTES + 1);
      else len = FRAME_BYTES + 1;
      send_byte(first_mk);
      send_byte(second_mk);
      send_byte(8'(len));
      for (int i = 0; i < len - 2; i++) send_byte(pick_payload());
      tail = ($urandom_range(99) < 85) ? end_mk : 8'($urandom);
      send_byte(tail);
      // byte after a frame, thrown away when the frame was good
      send_byte(8'($urandom));
      counted += len + 3;
    end else if (pick < 85) begin
      send_byte(first_mk);
      send_byte(second_mk);
      len = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(FRAME_BYTES + 2, 255);
      send_byte(8'(len));
      counted += 3;
    end else begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
      counted += len;
    end
  endtask

  task automatic run_random_phase();
    int counted;
    counted = 0;
    while (counted < PHASE_ITEMS) send_random_chunk(counted);
  endtask

  initial begin
    logic [7:0] directed [$];
    logic [7:0] f;
    logic [7:0] s;
    logic [7:0] e;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    set_markers(8'hA5, 8'h5A, 8'h7E);
    f = first_mk;
    s = second_mk;
    e = end_mk;
    directed = '{s, f, s, 8'h01, f, s, f, s, 8'h02, e, 8'hFF, f, s, 8'h12,
                 f, s, 8'h02, 8'h00, f, s, 8'h04, f, s, e, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);
    run_random_phase();

    set_markers(8'h00, 8'hFF, 8'h00);
    run_random_phase();

    steady = 1'b1;
    set_markers(8'hFF, 8'h00, 8'hFF);
    run_random_phase();
    steady = 1'b0;

    f = 8'($urandom);
    do s = 8'($urandom); while (s == f);
    set_markers(f, s, 8'($urandom));
    run_random_phase();

    @(negedge clk_i) rx_valid_i <= 1'b0;
    while (beats_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d serial bytes under %0d marker settings", bytes_sent, settings_used);
    $display("%0d frames delivered, %0d frame bytes compared, %0d mismatches",
             frames_passed, beats_compared, mismatches);
    if (mismatches == 0 && beats_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
